// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge of clk, skipped while rstn is low.
`define CIP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that sig never holds while rstn is high.
`define CIP_NEVER(lbl, clk, rstn, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(sig)) else $error(msg);

`endif

// ===== hw/rtl/cip_pkg.sv =====
package cip_pkg;

    // Operand and result widths on the streams
    localparam int DATA_W      = 32;
    localparam int WIDTH_DEF   = 32;
    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_TDATA_W = DATA_W;

endpackage

// ===== hw/rtl/cip_mul_step.sv =====
module cip_mul_step #(
    parameter int WIDTH = cip_pkg::WIDTH_DEF
) (
    input  logic [WIDTH-1:0]            i_acc,
    input  logic [cip_pkg::DATA_W-1:0]  i_base,
    output logic [WIDTH-1:0]            o_prod,
    output logic                        o_ovf
);

    localparam int PW = WIDTH + cip_pkg::DATA_W;

    logic [PW-1:0] w_full;

    // Multiply the partial power by the base at full width
    assign w_full = PW'(i_acc) * PW'(i_base);

    // Flag any product that needs more than WIDTH bits
    assign o_prod = w_full[WIDTH-1:0];
    assign o_ovf  = |w_full[PW-1:WIDTH];

endmodule

// ===== hw/rtl/checked_integer_power_top.sv =====
// Unsigned integer power with overflow check.
// Input stream: i_s_axis_tdata carries base (bits 31:0) and exponent (bits 63:32).
// Output stream: o_m_axis_tdata carries the power, o_m_axis_tuser the overflow flag.
// One item is in flight at a time; o_s_axis_tready is high only while the block is idle.
// Zero base, zero exponent and unit base finish without multiplying: the result is
// valid on the cycle after the input item is accepted.
// Otherwise one shared multiplier runs one step per cycle, min(exponent, k) steps,
// where k <= WIDTH is the step at which the product first needs more than WIDTH bits.
// After the result is taken, the block returns to idle.
// On overflow the power is the last partial power that fit and the flag is 1.
// When the receiver stalls, the result holds on the output and no new item is taken.
// Reset (synchronous, active low) returns the block to idle with no result pending.
module checked_integer_power_top #(
    parameter int WIDTH = cip_pkg::WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [cip_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // base, exponent
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [cip_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // power
    output logic                              o_m_axis_tuser   // overflow
);

    localparam int CW = $clog2(WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } t_state;

    t_state                       r_state;
    logic [WIDTH-1:0]             r_acc;
    logic [cip_pkg::DATA_W-1:0]   r_base;
    logic [CW-1:0]                r_rem;
    logic                         r_ovf;

    logic [cip_pkg::DATA_W-1:0]   w_base;
    logic [cip_pkg::DATA_W-1:0]   w_exp;
    logic [CW-1:0]                w_steps;
    logic [WIDTH-1:0]             w_prod;
    logic                         w_ovf;

    assign w_base = i_s_axis_tdata[cip_pkg::DATA_W-1:0];
    assign w_exp  = i_s_axis_tdata[cip_pkg::IN_TDATA_W-1:cip_pkg::DATA_W];

    // Any base of two or more overflows within WIDTH steps, so cap the count
    assign w_steps = (w_exp > cip_pkg::DATA_W'(WIDTH)) ? CW'(WIDTH) : w_exp[CW-1:0];

    // Shared multiply and range check
    cip_mul_step #(
        .WIDTH (WIDTH)
    ) u_mul (
        .i_acc  (r_acc),
        .i_base (r_base),
        .o_prod (w_prod),
        .o_ovf  (w_ovf)
    );

    // Sequence the steps and hold the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_base <= w_base;
                        r_ovf  <= 1'b0;
                        r_rem  <= w_steps;
                        if (w_base == '0) begin
                            r_acc   <= (w_exp == '0) ? WIDTH'(1) : '0;
                            r_state <= S_OUT;
                        end else if (w_exp == '0 || w_base == cip_pkg::DATA_W'(1)) begin
                            r_acc   <= WIDTH'(1);
                            r_state <= S_OUT;
                        end else begin
                            r_acc   <= WIDTH'(1);
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_ovf) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_acc <= w_prod;
                        r_rem <= r_rem - CW'(1);
                        if (r_rem == CW'(1)) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Drive the stream handshakes and the result
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = cip_pkg::OUT_TDATA_W'(r_acc);
    assign o_m_axis_tuser  = r_ovf;

endmodule

// ===== hw/rtl/cip_checker.sv =====
`include "assert_macros.svh"

module cip_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              i_s_axis_tready,
    input logic                              i_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [cip_pkg::OUT_TDATA_W-1:0]   i_m_axis_tdata,
    input logic                              i_m_axis_tuser
);

    // One item at a time: never take input while a result is shown
    `CIP_NEVER(a_one_in_flight, i_clk, i_rst_n,
        i_s_axis_tready && i_m_axis_tvalid,
        "input ready while result pending")

    // Drop ready once an item is taken
    `CIP_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        (i_s_axis_tvalid && i_s_axis_tready) |=> !i_s_axis_tready,
        "ready stayed high after accept")

    // Return to idle once the result is taken
    `CIP_ASSERT(a_idle_after_out, i_clk, i_rst_n,
        (i_m_axis_tvalid && i_m_axis_tready) |=> (i_s_axis_tready && !i_m_axis_tvalid),
        "no return to idle after result")

    // An overflowed result is the last power that fit, never zero
    `CIP_ASSERT(a_ovf_nonzero, i_clk, i_rst_n,
        (i_m_axis_tvalid && i_m_axis_tuser) |-> (i_m_axis_tdata != '0),
        "overflow with zero power")

    // Hold a stalled result
    `CIP_ASSERT(a_out_hold, i_clk, i_rst_n,
        (i_m_axis_tvalid && !i_m_axis_tready) |=>
            (i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser)),
        "stalled result changed")

endmodule

bind checked_integer_power_top cip_checker u_cip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

// ===== tb/tb_checked_integer_power_top.sv =====
`timescale 1ns / 1ps

module tb_checked_integer_power_top;

    localparam int WIDTH       = cip_pkg::WIDTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 2 * WIDTH + 8;
    localparam int RAND_ITEMS  = 460;
    localparam int CALM_ITEMS  = 40;

    typedef struct packed {
        logic [cip_pkg::DATA_W-1:0] power;
        logic                       overflow;
    } t_power_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [cip_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;   // base, exponent
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [cip_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;   // power
    logic                            o_m_axis_tuser;   // overflow

    t_power_result power_q[$];
    int            err_cnt;
    int            cyc_cnt;
    bit            src_idle_en;
    bit            sink_idle_en;
    int            sink_hold_len;

    checked_integer_power_top #(
        .WIDTH (WIDTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Toggle the clock every half period
    always #1 i_clk = ~i_clk;

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("tb_checked_integer_power_top: done, errors");
            $finish;
        end
    end

    // Compute base to the exponent by repeated multiply, stopping at the first
    // product that no longer fits in WIDTH bits
    function automatic t_power_result checked_power(input logic [31:0] base,
                                                    input logic [31:0] exponent);
        t_power_result res;
        logic [63:0]   acc;
        logic [63:0]   prod;
        int unsigned   step;
        bit            done;
        acc  = 64'd1;
        done = 1'b0;
        res.overflow = 1'b0;
        if (base == 32'd0) begin
            res.power = (exponent == 32'd0) ? 32'd1 : 32'd0;
        end else if (exponent == 32'd0 || base == 32'd1) begin
            res.power = 32'd1;
        end else begin
            step = 0;
            while (!done && step < exponent && step <= WIDTH + 1) begin
                prod = acc * {32'd0, base};
                if ((prod >> WIDTH) != 64'd0) begin
                    res.overflow = 1'b1;
                    done = 1'b1;
                end else begin
                    acc  = prod;
                    step = step + 1;
                end
            end
            res.power = acc[31:0];
        end
        return res;
    endfunction

    // Offer one item and hold it until the block takes it; tvalid stays high
    task automatic send_item(input logic [31:0] base, input logic [31:0] exponent);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {exponent, base};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        power_q.push_back(checked_power(base, exponent));
    endtask

    // Drop tvalid for a random burst when sender idling is on
    task automatic source_gap();
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every pending result has come back
    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (power_q.size() != 0) @(posedge i_clk);
    endtask

    // Pick operands biased toward special values and the overflow boundary
    task automatic pick_operands(output logic [31:0] base, output logic [31:0] exponent);
        int unsigned sel_b;
        int unsigned sel_e;
        sel_b = $urandom_range(0, 9);
        sel_e = $urandom_range(0, 7);
        unique case (sel_b)
            0:       base = 32'd0;
            1:       base = 32'd1;
            2, 3, 4: base = $urandom_range(2, 16);
            5, 6:    base = $urandom_range(17, 32'hFFFF);
            default: base = $urandom;
        endcase
        unique case (sel_e)
            0:       exponent = 32'd0;
            1, 2, 3,
            4:       exponent = $urandom_range(1, 40);
            5:       exponent = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: exponent = $urandom;
        endcase
    endtask

    // Sink side: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (sink_hold_len != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (sink_hold_len) @(posedge i_clk);
                sink_hold_len = 0;
                i_m_axis_tready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result item with the oldest pending prediction
    always @(posedge i_clk) begin : chk_result
        t_power_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (power_q.size() == 0) begin
                $display("%0t: unexpected result power=%h overflow=%b", $time,
                         o_m_axis_tdata, o_m_axis_tuser);
                err_cnt++;
            end else begin
                want = power_q.pop_front();
                if (o_m_axis_tdata !== want.power) begin
                    $display("%0t: power mismatch expected=%h actual=%h", $time,
                             want.power, o_m_axis_tdata);
                    err_cnt++;
                end
                if (o_m_axis_tuser !== want.overflow) begin
                    $display("%0t: overflow mismatch expected=%b actual=%b", $time,
                             want.overflow, o_m_axis_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // Zero base, zero exponent and unit base
    task automatic test_special_operands();
        send_item(32'd0, 32'd0);
        send_item(32'd0, 32'd1);
        send_item(32'd0, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd0);
        send_item(32'd5, 32'd0);
        send_item(32'd1, 32'd0);
        send_item(32'd1, 32'hFFFF_FFFF);
        send_item(32'd1, 32'd7);
        wait_drain();
    endtask

    // Powers right at and past the top of the result range
    task automatic test_power_boundaries();
        send_item(32'd2, 32'd31);
        send_item(32'd2, 32'd32);
        send_item(32'd2, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd1);
        send_item(32'hFFFF_FFFF, 32'd2);
        send_item(32'h0001_0000, 32'd2);
        send_item(32'h0000_FFFF, 32'd2);
        send_item(32'd3, 32'd20);
        send_item(32'd3, 32'd21);
        send_item(32'd7, 32'd11);
        send_item(32'd7, 32'd12);
        send_item(32'h8000_0000, 32'd1);
        send_item(32'h8000_0000, 32'd2);
        send_item(32'hAAAA_AAAA, 32'h5555_5555);
        wait_drain();
    endtask

    // Hold the sink for a long stretch while items keep coming
    task automatic test_output_backpressure();
        logic [31:0] base;
        logic [31:0] exponent;
        sink_hold_len = 150;
        repeat (10) begin
            pick_operands(base, exponent);
            send_item(base, exponent);
        end
        wait_drain();
    endtask

    // Random operands with idling on both sides in stretches
    task automatic test_random_operands(input int count);
        logic [31:0] base;
        logic [31:0] exponent;
        for (int n = 0; n < count; n++) begin
            if (n % 48 == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (n == count / 2) begin
                // pause the sender until all results are back
                wait_drain();
            end
            pick_operands(base, exponent);
            send_item(base, exponent);
            source_gap();
        end
    endtask

    // Back to back items with no idling on either side
    task automatic test_full_rate(input int count);
        logic [31:0] base;
        logic [31:0] exponent;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (count) begin
            pick_operands(base, exponent);
            send_item(base, exponent);
        end
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        err_cnt         = 0;
        cyc_cnt         = 0;
        src_idle_en     = 1'b0;
        sink_idle_en    = 1'b0;
        sink_hold_len   = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_operands();
        test_power_boundaries();
        test_output_backpressure();
        test_random_operands(RAND_ITEMS);
        test_full_rate(CALM_ITEMS);

        wait_drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_checked_integer_power_top: done, clean");
        end else begin
            $display("tb_checked_integer_power_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/cip_pkg.sv
hw/rtl/cip_mul_step.sv
hw/rtl/checked_integer_power_top.sv
hw/rtl/cip_checker.sv
tb/tb_checked_integer_power_top.sv
